FILE: hw/rtl/lps_pkg.sv
`default_nettype none

package lps_pkg;

  // Number of LEDs driven by the sequencer (valid range 2 to 16).
  localparam int unsigned NumLeds = 8;

  // Step counter width: the longest effect (marquee) has 4 * NumLeds + 1 steps.
  localparam int unsigned StepW   = $clog2(4 * NumLeds + 2);
  localparam int unsigned DelayW  = 12;
  localparam int unsigned WaitW   = DelayW + 2;
  localparam int unsigned RepW    = 8;
  localparam int unsigned EffW    = 4;
  localparam int unsigned LedOutW = 8;
  localparam int unsigned LedExtW = (NumLeds > LedOutW) ? NumLeds : LedOutW;

  localparam logic [DelayW-1:0] StepDelayRst   = DelayW'(50);
  localparam logic [RepW-1:0]   RepeatCountRst = RepW'(4);

  typedef enum logic {
    REQ_TICK  = 1'b0,
    REQ_START = 1'b1
  } req_type_e;

  typedef enum logic {
    CFG_STEP_DELAY   = 1'b0,
    CFG_REPEAT_COUNT = 1'b1
  } cfg_idx_e;

  typedef enum logic [EffW-1:0] {
    EFF_DOUBLE      = 4'd0,
    EFF_DOUBLE_REV  = 4'd1,
    EFF_FWD_BACK    = 4'd2,
    EFF_BACK_FWD    = 4'd3,
    EFF_BLINK_SLOW  = 4'd4,
    EFF_BLINK_FAST  = 4'd5,
    EFF_JAWS        = 4'd6,
    EFF_MARQUEE     = 4'd7,
    EFF_FAST_FWD    = 4'd8,
    EFF_FAST_REV    = 4'd9
  } effect_e;

  typedef enum logic [1:0] {
    DK_BASE = 2'd0,
    DK_X4   = 2'd1,
    DK_HALF = 2'd2
  } delay_kind_e;

  typedef struct packed {
    logic                req_type;
    logic [EffW-1:0]     pattern_sel;
  } cmd_t;

  typedef struct packed {
    logic                finished;
    logic                busy_res;
    logic [LedOutW-1:0]  led_bits;
  } res_t;

  typedef struct packed {
    logic                running;
    logic [NumLeds-1:0]  leds;
  } stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lps_step_gen.sv
`default_nettype none

// Decodes one step of an effect and applies it to the current LED levels.
module lps_step_gen (
  input  wire logic [lps_pkg::EffW-1:0]    effect_i,
  input  wire logic [lps_pkg::StepW-1:0]   index_i,
  input  wire logic [lps_pkg::DelayW-1:0]  step_delay_i,
  input  wire logic [lps_pkg::NumLeds-1:0] leds_i,
  output logic      [lps_pkg::NumLeds-1:0] leds_o,
  output logic      [lps_pkg::WaitW-1:0]   wait_o
);

  localparam logic [lps_pkg::StepW-1:0] N  = lps_pkg::StepW'(lps_pkg::NumLeds);
  localparam logic [lps_pkg::StepW-1:0] H  = lps_pkg::StepW'(lps_pkg::NumLeds / 2);
  localparam logic [lps_pkg::StepW-1:0] H2 = lps_pkg::StepW'(2 * (lps_pkg::NumLeds / 2));
  localparam logic [lps_pkg::StepW-1:0] N2 = lps_pkg::StepW'(2 * lps_pkg::NumLeds);
  localparam logic [lps_pkg::StepW-1:0] N4 = lps_pkg::StepW'(4 * lps_pkg::NumLeds);

  // One-hot LED mask, counted from either end of the bar.
  function automatic logic [lps_pkg::NumLeds-1:0] sweep_bit(
    input logic rev, input logic [lps_pkg::StepW-1:0] k);
    logic [lps_pkg::StepW-1:0] pos;
    pos = rev ? (N - lps_pkg::StepW'(1) - k) : k;
    return lps_pkg::NumLeds'(1) << pos;
  endfunction

  logic                             clr;
  logic                             set_all;
  logic [lps_pkg::NumLeds-1:0]      flip;
  lps_pkg::delay_kind_e             dkind;
  logic                             r1;
  logic                             r2;
  logic [lps_pkg::StepW-1:0]        k;
  logic [lps_pkg::NumLeds-1:0]      base;
  logic [lps_pkg::WaitW-1:0]        dly;

  always_comb begin
    clr     = 1'b0;
    set_all = 1'b0;
    flip    = '0;
    dkind   = lps_pkg::DK_BASE;
    r1      = (effect_i == lps_pkg::EFF_DOUBLE_REV) || (effect_i == lps_pkg::EFF_BACK_FWD);
    r2      = (effect_i == lps_pkg::EFF_DOUBLE_REV) || (effect_i == lps_pkg::EFF_FWD_BACK);
    k       = (index_i < H) ? index_i : (H2 - lps_pkg::StepW'(1) - index_i);
    unique case (effect_i) inside
      lps_pkg::EFF_DOUBLE, lps_pkg::EFF_DOUBLE_REV,
      lps_pkg::EFF_FWD_BACK, lps_pkg::EFF_BACK_FWD: begin
        // Fill pass, one idle step, the clearing pass, then one more idle step.
        if (index_i < N) begin
          clr  = (index_i == '0);
          flip = sweep_bit(r1, index_i);
        end else if (index_i > N && index_i < N2 + lps_pkg::StepW'(1)) begin
          flip = sweep_bit(r2, index_i - N - lps_pkg::StepW'(1));
        end
      end
      lps_pkg::EFF_BLINK_SLOW: begin
        dkind = lps_pkg::DK_X4;
        if (index_i == '0) begin
          set_all = 1'b1;
        end else begin
          clr = 1'b1;
        end
      end
      lps_pkg::EFF_BLINK_FAST: begin
        if (index_i[0]) begin
          clr = 1'b1;
        end else begin
          set_all = 1'b1;
        end
      end
      lps_pkg::EFF_JAWS: begin
        // Both ends close toward the middle, then open again.
        if (index_i < H2) begin
          clr  = (index_i == '0);
          flip = sweep_bit(1'b0, k) | sweep_bit(1'b1, k);
        end
      end
      lps_pkg::EFF_MARQUEE: begin
        if (index_i < N2) begin
          clr  = (index_i == '0);
          flip = sweep_bit(1'b0, index_i >> 1);
        end else if (index_i < N4) begin
          clr  = (index_i == N2);
          flip = sweep_bit(1'b1, (index_i - N2) >> 1);
        end
      end
      lps_pkg::EFF_FAST_FWD, lps_pkg::EFF_FAST_REV: begin
        dkind = lps_pkg::DK_HALF;
        clr   = (index_i == '0);
        flip  = sweep_bit(effect_i == lps_pkg::EFF_FAST_REV, index_i >> 1);
      end
      default: begin
      end
    endcase

    base = leds_i;
    if (clr) begin
      base = '0;
    end
    if (set_all) begin
      base = '1;
    end
    leds_o = base ^ flip;

    case (dkind)
      lps_pkg::DK_X4:   dly = {step_delay_i, 2'b00};
      lps_pkg::DK_HALF: dly = lps_pkg::WaitW'(step_delay_i >> 1);
      default:          dly = lps_pkg::WaitW'(step_delay_i);
    endcase
    wait_o = (dly == '0) ? lps_pkg::WaitW'(1) : dly;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lps_seq_core.sv
`default_nettype none

// Sequencer state: effect, repeat and step counters, tick countdown.
module lps_seq_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        accept_i,
  input  wire lps_pkg::cmd_t               cmd_i,
  input  wire logic [lps_pkg::DelayW-1:0]  step_delay_i,
  input  wire logic [lps_pkg::RepW-1:0]    repeat_count_i,
  output lps_pkg::res_t                    res_o,
  output lps_pkg::stat_t                   stat_o
);

  function automatic logic [lps_pkg::StepW-1:0] step_total(input logic [lps_pkg::EffW-1:0] e);
    unique case (e) inside
      lps_pkg::EFF_DOUBLE, lps_pkg::EFF_DOUBLE_REV,
      lps_pkg::EFF_FWD_BACK, lps_pkg::EFF_BACK_FWD:
        return lps_pkg::StepW'(2 * lps_pkg::NumLeds + 2);
      lps_pkg::EFF_BLINK_SLOW: return lps_pkg::StepW'(2);
      lps_pkg::EFF_BLINK_FAST: return lps_pkg::StepW'(4);
      lps_pkg::EFF_JAWS:       return lps_pkg::StepW'(2 * (lps_pkg::NumLeds / 2) + 1);
      lps_pkg::EFF_MARQUEE:    return lps_pkg::StepW'(4 * lps_pkg::NumLeds + 1);
      lps_pkg::EFF_FAST_FWD, lps_pkg::EFF_FAST_REV:
        return lps_pkg::StepW'(2 * lps_pkg::NumLeds);
      default:                 return '0;
    endcase
  endfunction

  logic [lps_pkg::NumLeds-1:0] led_q, led_d;
  logic [lps_pkg::EffW-1:0]    eff_q, eff_d;
  logic [lps_pkg::RepW-1:0]    rep_q, rep_d;
  logic [lps_pkg::StepW-1:0]   idx_q, idx_d;
  logic [lps_pkg::WaitW-1:0]   wait_q, wait_d;
  logic                        run_q, run_d;
  logic                        fin;

  logic [lps_pkg::EffW-1:0]    gen_eff;
  logic [lps_pkg::StepW-1:0]   gen_idx;
  logic [lps_pkg::StepW-1:0]   idx_inc;
  logic [lps_pkg::RepW-1:0]    rep_dec;
  logic                        wrap;
  logic [lps_pkg::NumLeds-1:0] gen_leds;
  logic [lps_pkg::WaitW-1:0]   gen_wait;
  logic [lps_pkg::LedExtW-1:0] led_ext;
  logic                        is_start;

  assign is_start = (cmd_i.req_type == lps_pkg::REQ_START);
  assign idx_inc  = idx_q + lps_pkg::StepW'(1);
  assign wrap     = (idx_inc >= step_total(eff_q));
  assign rep_dec  = rep_q - lps_pkg::RepW'(1);
  // A start always begins at step zero; a tick begins the next step or the next repeat.
  assign gen_eff  = is_start ? cmd_i.pattern_sel : eff_q;
  assign gen_idx  = (is_start || wrap) ? '0 : idx_inc;

  lps_step_gen u_step_gen (
    .effect_i     (gen_eff),
    .index_i      (gen_idx),
    .step_delay_i (step_delay_i),
    .leds_i       (led_q),
    .leds_o       (gen_leds),
    .wait_o       (gen_wait)
  );

  always_comb begin
    led_d  = led_q;
    eff_d  = eff_q;
    rep_d  = rep_q;
    idx_d  = idx_q;
    wait_d = wait_q;
    run_d  = run_q;
    fin    = 1'b0;
    if (is_start) begin
      if (!run_q) begin
        eff_d = cmd_i.pattern_sel;
        idx_d = '0;
        if (cmd_i.pattern_sel > lps_pkg::EFF_FAST_REV || repeat_count_i == '0) begin
          rep_d  = '0;
          wait_d = '0;
          fin    = 1'b1;
        end else begin
          rep_d  = repeat_count_i;
          run_d  = 1'b1;
          led_d  = gen_leds;
          wait_d = gen_wait;
        end
      end
    end else if (run_q) begin
      if (wait_q > lps_pkg::WaitW'(1)) begin
        wait_d = wait_q - lps_pkg::WaitW'(1);
      end else if (wrap) begin
        rep_d = rep_dec;
        idx_d = '0;
        if (rep_dec == '0) begin
          run_d  = 1'b0;
          wait_d = '0;
          fin    = 1'b1;
        end else begin
          led_d  = gen_leds;
          wait_d = gen_wait;
        end
      end else begin
        idx_d  = idx_inc;
        led_d  = gen_leds;
        wait_d = gen_wait;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_q  <= '0;
      eff_q  <= '0;
      rep_q  <= '0;
      idx_q  <= '0;
      wait_q <= '0;
      run_q  <= 1'b0;
    end else if (accept_i) begin
      led_q  <= led_d;
      eff_q  <= eff_d;
      rep_q  <= rep_d;
      idx_q  <= idx_d;
      wait_q <= wait_d;
      run_q  <= run_d;
    end
  end

  assign led_ext         = lps_pkg::LedExtW'(led_d);
  assign res_o.led_bits  = led_ext[lps_pkg::LedOutW-1:0];
  assign res_o.busy_res  = run_d;
  assign res_o.finished  = fin;
  assign stat_o.running  = run_q;
  assign stat_o.leds     = led_q;

endmodule

`default_nettype wire

FILE: hw/rtl/led_pattern_sequencer_unit.sv
// LED pattern sequencer: steps a bar of LEDs through one of ten effects.
//
// Input stream (s_axis_*): one beat is either a one-millisecond tick
// (tuser = 0) or a start request (tuser = 1) carrying the effect number in
// tdata[3:0]. Effects 10 to 15 end at once, as does a start with a repeat
// count of zero; a start while an effect runs is ignored.
// Output stream (m_axis_*): exactly one result beat per input beat, carrying
// the LED levels after the beat, a busy flag and a finished flag.
// Configuration: cfg_we_i writes cfg_data_i into the register chosen by
// cfg_idx_i (0 = step delay in ticks, 1 = repeat count). Write only while
// no result is outstanding.
//
// The sequencer state and the result register both load on the edge that
// accepts the beat. A beat can be accepted every cycle while the receiver
// takes each result; the only storage in the path is the single result
// register. When the receiver stalls, the result holds and s_axis_tready
// drops until the result beat is taken; a new beat is accepted in the same
// cycle in which the held result leaves.
// Reset turns all LEDs off, stops any effect, clears the output register
// and restores step delay 50 and repeat count 4.

`default_nettype none

module led_pattern_sequencer_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_idx_i,
  input  wire logic [lps_pkg::DelayW-1:0]  cfg_data_i,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [7:0]                  s_axis_tdata,   // [3:0] pattern_sel, [7:4] zero
  input  wire logic                        s_axis_tuser,   // [0] req_type
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [15:0]                      m_axis_tdata    // [7:0] led_bits, [8] busy_res,
                                                           // [9] finished, [15:10] zero
);

  logic [lps_pkg::DelayW-1:0] step_delay_q;
  logic [lps_pkg::RepW-1:0]   repeat_count_q;
  logic                       out_valid_q, out_valid_d;
  lps_pkg::res_t              res_q;
  lps_pkg::res_t              res_d;
  lps_pkg::stat_t             stat;
  lps_pkg::cmd_t              cmd;
  logic                       s_accept;

  // Configuration registers. The delay is sampled when each step begins,
  // so a write between effects takes hold at the next step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_delay_q   <= lps_pkg::StepDelayRst;
      repeat_count_q <= lps_pkg::RepeatCountRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lps_pkg::CFG_STEP_DELAY:   step_delay_q   <= cfg_data_i;
        lps_pkg::CFG_REPEAT_COUNT: repeat_count_q <= cfg_data_i[lps_pkg::RepW-1:0];
        default: begin
        end
      endcase
    end
  end

  // The input side is free whenever the result register is empty or is
  // being drained in this very cycle.
  assign s_axis_tready    = !out_valid_q || m_axis_tready;
  assign s_accept         = s_axis_tvalid && s_axis_tready;
  assign cmd.req_type     = s_axis_tuser;
  assign cmd.pattern_sel  = s_axis_tdata[lps_pkg::EffW-1:0];

  lps_seq_core u_seq_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (s_accept),
    .cmd_i          (cmd),
    .step_delay_i   (step_delay_q),
    .repeat_count_i (repeat_count_q),
    .res_o          (res_d),
    .stat_o         (stat)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (s_accept) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload: loaded only with an accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (s_accept) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = 16'(res_q);

  // An effect can never be both finished and still running.
  a_fin_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[9] && m_axis_tdata[8]))
    else $error("finished result still reports busy");

  // A valid start while idle must leave the sequencer running.
  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && s_axis_tuser && !stat.running &&
     s_axis_tdata[lps_pkg::EffW-1:0] <= lps_pkg::EFF_FAST_REV && repeat_count_q != '0)
    |=> stat.running)
    else $error("start request did not launch an effect");

  // A tick while idle changes nothing.
  a_idle_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && !s_axis_tuser && !stat.running)
    |=> (!stat.running && stat.leds == $past(stat.leds) && !res_q.finished))
    else $error("idle tick altered the sequencer state");

  // The result register mirrors the sequencer's running flag after a beat.
  a_busy_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> (res_q.busy_res == stat.running))
    else $error("busy flag out of step with sequencer state");

endmodule

`default_nettype wire
